>>> rtl/sequential_ratio_test_macros.svh
// Assertion macros shared by the sequential ratio test RTL.
// Needs nothing else; included by the files that carry concurrent checks.
`ifndef SEQUENTIAL_RATIO_TEST_MACROS_SVH
`define SEQUENTIAL_RATIO_TEST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequential_ratio_test: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequential_ratio_test: next-cycle check failed");

`endif

>>> rtl/srt_pkg.sv
// Shared widths, codes and helper functions for the sequential ratio test.
// No dependencies; imported by srt_div and sequential_ratio_test.
package srt_pkg;

  // Datapath sizes.
  localparam int COUNT_BITS    = 32;
  localparam int SUM_BITS      = 48;
  localparam int FRACTION_BITS = 16;

  // Register field widths.
  localparam int STEP_BITS  = 24;
  localparam int THR_BITS   = 23;
  localparam int BOUND_BITS = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Stream widths.
  localparam int IN_DATA_W     = 8;
  localparam int IN_USER_W     = 1;
  localparam int OUT_FIELDS_W  = 2 + 2 * COUNT_BITS + FRACTION_BITS + 1;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Input operation codes.
  localparam logic OP_TRIAL = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE          = 3'd0,
    CFG_SUCCESS_STEP  = 3'd1,
    CFG_FAILURE_STEP  = 3'd2,
    CFG_LOG_THRESHOLD = 3'd3,
    CFG_SAMPLE_BOUND  = 3'd4
  } cfg_reg_e;

  // Test outcome reported as status.
  typedef enum logic [1:0] {
    VERDICT_RUN    = 2'd0,
    VERDICT_ACCEPT = 2'd1,
    VERDICT_REJECT = 2'd2,
    VERDICT_EST    = 2'd3
  } verdict_e;

  // Divider status towards the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Low bits of the sample bound, in the width of the trial counter.
  function automatic logic [COUNT_BITS-1:0] bound_low(input logic [BOUND_BITS-1:0] b);
    logic [63:0] w;
    w = 64'(b);
    return w[COUNT_BITS-1:0];
  endfunction

  // True when the bound lies beyond what the trial counter can reach.
  function automatic logic bound_over(input logic [BOUND_BITS-1:0] b);
    logic [63:0] w;
    w = 64'(b);
    return |(w >> COUNT_BITS);
  endfunction

endpackage

>>> rtl/srt_div.sv
// Bit-serial restoring divider giving floor(x * 2^FRACTION_BITS / n) for x <= n.
// Depends on srt_pkg for widths and the status struct.
module srt_div import srt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [COUNT_BITS-1:0]    dividend_i,
  input  logic [COUNT_BITS-1:0]    divisor_i,
  output div_stat_t                stat_o,
  output logic [FRACTION_BITS:0]   quotient_o
);

  localparam int DBIT_W = $clog2(COUNT_BITS + 1);
  localparam int ITER_W = $clog2(FRACTION_BITS + 1);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [DBIT_W-1:0]       bit_q, bit_d;
  logic [ITER_W-1:0]       iter_q, iter_d;
  logic                    bw_q, bw_d;
  logic [COUNT_BITS:0]     rem_q, rem_d;
  logic [COUNT_BITS:0]     dif_q, dif_d;
  logic [COUNT_BITS:0]     dvs_q, dvs_d;
  logic [FRACTION_BITS:0]  quo_q, quo_d;

  logic                    r_bit, d_bit, df_bit, bw_nxt, ge;
  logic [COUNT_BITS:0]     rem_rot, dif_new, rem_nxt;

  // One bit of the trial subtraction per cycle, least significant first.
  assign r_bit   = rem_q[0];
  assign d_bit   = dvs_q[0];
  assign df_bit  = r_bit ^ d_bit ^ bw_q;
  assign bw_nxt  = (~r_bit & d_bit) | (~(r_bit ^ d_bit) & bw_q);
  assign rem_rot = {r_bit, rem_q[COUNT_BITS:1]};
  assign dif_new = {df_bit, dif_q[COUNT_BITS:1]};
  assign ge      = ~bw_nxt;
  assign rem_nxt = ge ? dif_new : rem_rot;

  // Sequencing of bits within a pass and passes within a division.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    bit_d  = bit_q;
    iter_d = iter_q;
    bw_d   = bw_q;
    rem_d  = rem_q;
    dif_d  = dif_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = '0;
      iter_d = '0;
      bw_d   = 1'b0;
      rem_d  = {1'b0, dividend_i};
      dvs_d  = {1'b0, divisor_i};
    end else if (busy_q) begin
      if (bit_q == DBIT_W'(COUNT_BITS)) begin
        // End of a pass: keep the difference if no borrow, then double.
        rem_d = {rem_nxt[COUNT_BITS-1:0], 1'b0};
        dvs_d = {1'b0, divisor_i};
        bw_d  = 1'b0;
        bit_d = '0;
        quo_d = {quo_q[FRACTION_BITS-1:0], ge};
        if (iter_q == ITER_W'(FRACTION_BITS)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end else begin
        rem_d = rem_rot;
        dif_d = dif_new;
        dvs_d = {1'b0, dvs_q[COUNT_BITS:1]};
        bw_d  = bw_nxt;
        bit_d = bit_q + 1'b1;
      end
    end
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
      iter_q <= iter_d;
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk_i) begin
    bw_q  <= bw_d;
    rem_q <= rem_d;
    dif_q <= dif_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

>>> rtl/sequential_ratio_test.sv
// Top level of the sequential ratio test: bit-serial counters, sum and compares.
// Depends on srt_pkg, srt_div and sequential_ratio_test_macros.svh.
//
//   channel   direction  handshake                   beat contents
//   s_axis    in         s_axis_tvalid/tready        tuser: op; tdata: outcome
//   m_axis    out        m_axis_tvalid/tready        status, samples, successes, estimate
//   cfg       in         cfg_valid_i/cfg_ready_o     register index, write data
//
// A trial runs the one-bit counter pass (S_CNT), then in ratio mode the sum pass
// (S_ADD) and the check pass (S_CHK), and ends in S_FIN. The stopping trial in
// bound mode also runs the serial divider (S_DIV). A clear, or a trial after a
// verdict, goes from S_IDLE straight to S_FIN.
// Reset brings every count, the sum and the verdict to zero at once; no sweep.
// Input is taken only between items; a finished result waits in the output
// register while the next item is worked on, and a stalled output holds the
// block at its last cycle of work.
`include "sequential_ratio_test_macros.svh"

module sequential_ratio_test import srt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // [0] outcome, rest zero
  input  logic [IN_USER_W-1:0]   s_axis_tuser,   // [0] op
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // status, samples, successes, estimate
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int PASS_MAX = (SUM_BITS > COUNT_BITS) ? SUM_BITS : COUNT_BITS;
  localparam int BIT_W    = $clog2(PASS_MAX);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CNT  = 6'b000010,
    S_ADD  = 6'b000100,
    S_CHK  = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic [BIT_W-1:0]         bit_q, bit_d;

  // Configuration registers.
  logic                     mode_q, mode_d;
  logic [STEP_BITS-1:0]     sstep_q, sstep_d;
  logic [STEP_BITS-1:0]     fstep_q, fstep_d;
  logic [THR_BITS-1:0]      thr_q, thr_d;
  logic [COUNT_BITS-1:0]    bnd_q, bnd_d;
  logic                     bnd_over_q, bnd_over_d;

  // Test state.
  logic [COUNT_BITS-1:0]    trial_q, trial_d;
  logic [COUNT_BITS-1:0]    succ_q, succ_d;
  logic                     tfull_q, tfull_d;
  logic                     sfull_q, sfull_d;
  logic [SUM_BITS-1:0]      sum_q, sum_d;
  verdict_e                 verdict_q, verdict_d;
  logic [FRACTION_BITS:0]   frac_q, frac_d;

  // Serial working bits.
  logic                     tc_q, tc_d, sc_q, sc_d;
  logic                     tand_q, tand_d, sand_q, sand_d;
  logic                     ge_q, ge_d;
  logic [STEP_BITS-1:0]     step_q, step_d;
  logic                     ac_q, ac_d;
  logic                     ovf_q, ovf_d, neg_q, neg_d;
  logic [THR_BITS-1:0]      thr_sh_q, thr_sh_d;
  logic                     gt_q, gt_d, lc_q, lc_d;
  logic                     div_start_q, div_start_d;

  // Output register.
  logic                     m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0]    m_data_q, m_data_d;

  div_stat_t                div_stat;
  logic [FRACTION_BITS:0]   div_quo;

  logic                     in_beat, cfg_beat, out_free;
  logic                     last_cnt, last_sum;
  logic                     t_bit, t_sum, t_car, s_bit, s_sum, s_car, ge_nxt;
  logic                     a_bit, b_bit, a_sum, a_car;
  logic                     msb, c_bit, th_bit, c_a, c_b, gt_nxt, lc_nxt, lt;
  logic [FRACTION_BITS:0]   est;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign cfg_beat      = cfg_valid_i & cfg_ready_o;
  assign out_free      = ~m_valid_q | m_axis_tready;
  assign last_cnt      = (bit_q == BIT_W'(COUNT_BITS - 1));
  assign last_sum      = (bit_q == BIT_W'(SUM_BITS - 1));

  // Counter pass: serial saturating increments and the bound compare.
  assign t_bit  = trial_q[0];
  assign t_sum  = t_bit ^ tc_q;
  assign t_car  = t_bit & tc_q;
  assign s_bit  = succ_q[0];
  assign s_sum  = s_bit ^ sc_q;
  assign s_car  = s_bit & sc_q;
  assign ge_nxt = (t_sum != bnd_q[0]) ? t_sum : ge_q;

  // Sum pass: serial add of the sign-extended step.
  assign a_bit = sum_q[0];
  assign b_bit = step_q[0];
  assign a_sum = a_bit ^ b_bit ^ ac_q;
  assign a_car = (a_bit & b_bit) | (ac_q & (a_bit ^ b_bit));

  // Check pass: saturate the sum, then compare against both thresholds.
  assign msb    = last_sum;
  assign c_bit  = ovf_q ? (neg_q ^ ~msb) : sum_q[0];
  assign th_bit = thr_sh_q[0];
  assign c_a    = c_bit ^ msb;
  assign c_b    = th_bit ^ msb;
  assign gt_nxt = (c_a != c_b) ? c_a : gt_q;
  assign lc_nxt = (c_bit & th_bit) | (lc_q & (c_bit ^ th_bit));
  assign lt     = c_bit ^ lc_nxt;

  assign est = (verdict_q == VERDICT_EST) ? frac_q : '0;

  // Next-state logic for the controller, the datapath and the registers.
  always_comb begin
    state_d     = state_q;
    bit_d       = bit_q;
    mode_d      = mode_q;
    sstep_d     = sstep_q;
    fstep_d     = fstep_q;
    thr_d       = thr_q;
    bnd_d       = bnd_q;
    bnd_over_d  = bnd_over_q;
    trial_d     = trial_q;
    succ_d      = succ_q;
    tfull_d     = tfull_q;
    sfull_d     = sfull_q;
    sum_d       = sum_q;
    verdict_d   = verdict_q;
    frac_d      = frac_q;
    tc_d        = tc_q;
    sc_d        = sc_q;
    tand_d      = tand_q;
    sand_d      = sand_q;
    ge_d        = ge_q;
    step_d      = step_q;
    ac_d        = ac_q;
    ovf_d       = ovf_q;
    neg_d       = neg_q;
    thr_sh_d    = thr_sh_q;
    gt_d        = gt_q;
    lc_d        = lc_q;
    div_start_d = 1'b0;
    m_valid_d   = m_valid_q & ~m_axis_tready;
    m_data_d    = m_data_q;

    // Register writes are to arrive only while no item is in flight; the block does not enforce it.
    if (cfg_beat) begin
      case (cfg_index_i)
        CFG_MODE:          mode_d  = cfg_data_i[0];
        CFG_SUCCESS_STEP:  sstep_d = cfg_data_i[STEP_BITS-1:0];
        CFG_FAILURE_STEP:  fstep_d = cfg_data_i[STEP_BITS-1:0];
        CFG_LOG_THRESHOLD: thr_d   = cfg_data_i[THR_BITS-1:0];
        CFG_SAMPLE_BOUND: begin
          bnd_d      = bound_low(cfg_data_i[BOUND_BITS-1:0]);
          bnd_over_d = bound_over(cfg_data_i[BOUND_BITS-1:0]);
        end
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          bit_d = '0;
          if (s_axis_tuser[0] == OP_CLEAR) begin
            trial_d   = '0;
            succ_d    = '0;
            tfull_d   = 1'b0;
            sfull_d   = 1'b0;
            sum_d     = '0;
            verdict_d = VERDICT_RUN;
            frac_d    = '0;
            state_d   = S_FIN;
          end else if (verdict_q != VERDICT_RUN) begin
            state_d = S_FIN;
          end else begin
            tc_d    = ~tfull_q;
            sc_d    = s_axis_tdata[0] & ~sfull_q;
            tand_d  = 1'b1;
            sand_d  = 1'b1;
            ge_d    = 1'b1;
            ac_d    = 1'b0;
            step_d  = s_axis_tdata[0] ? sstep_q : fstep_q;
            state_d = S_CNT;
          end
        end
      end

      S_CNT: begin
        trial_d = {t_sum, trial_q[COUNT_BITS-1:1]};
        succ_d  = {s_sum, succ_q[COUNT_BITS-1:1]};
        bnd_d   = {bnd_q[0], bnd_q[COUNT_BITS-1:1]};
        tc_d    = t_car;
        sc_d    = s_car;
        tand_d  = tand_q & t_sum;
        sand_d  = sand_q & s_sum;
        ge_d    = ge_nxt;
        if (last_cnt) begin
          tfull_d = tand_q & t_sum;
          sfull_d = sand_q & s_sum;
          bit_d   = '0;
          if (!mode_q) begin
            state_d = S_ADD;
          end else if (ge_nxt && !bnd_over_q) begin
            div_start_d = 1'b1;
            state_d     = S_DIV;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          bit_d = bit_q + 1'b1;
        end
      end

      S_ADD: begin
        sum_d  = {a_sum, sum_q[SUM_BITS-1:1]};
        step_d = {step_q[STEP_BITS-1], step_q[STEP_BITS-1:1]};
        ac_d   = a_car;
        if (last_sum) begin
          // Overflow when both operands share a sign the result lacks.
          ovf_d    = (a_bit == b_bit) && (a_sum != a_bit);
          neg_d    = a_bit;
          thr_sh_d = thr_q;
          gt_d     = 1'b0;
          lc_d     = 1'b0;
          bit_d    = '0;
          state_d  = S_CHK;
        end else begin
          bit_d = bit_q + 1'b1;
        end
      end

      S_CHK: begin
        sum_d    = {c_bit, sum_q[SUM_BITS-1:1]};
        thr_sh_d = {1'b0, thr_sh_q[THR_BITS-1:1]};
        gt_d     = gt_nxt;
        lc_d     = lc_nxt;
        if (last_sum) begin
          if (gt_nxt) begin
            verdict_d = VERDICT_ACCEPT;
          end else if (lt) begin
            verdict_d = VERDICT_REJECT;
          end
          bit_d   = '0;
          state_d = S_FIN;
        end else begin
          bit_d = bit_q + 1'b1;
        end
      end

      S_DIV: begin
        if (div_stat.done) begin
          frac_d    = div_quo;
          verdict_d = VERDICT_EST;
          state_d   = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_DATA_W'({est, succ_q, trial_q, verdict_q});
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state, counts, sum and registers with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bit_q       <= '0;
      mode_q      <= 1'b0;
      sstep_q     <= '0;
      fstep_q     <= '0;
      thr_q       <= '0;
      bnd_q       <= COUNT_BITS'(1);
      bnd_over_q  <= 1'b0;
      trial_q     <= '0;
      succ_q      <= '0;
      tfull_q     <= 1'b0;
      sfull_q     <= 1'b0;
      sum_q       <= '0;
      verdict_q   <= VERDICT_RUN;
      frac_q      <= '0;
      div_start_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_q       <= bit_d;
      mode_q      <= mode_d;
      sstep_q     <= sstep_d;
      fstep_q     <= fstep_d;
      thr_q       <= thr_d;
      bnd_q       <= bnd_d;
      bnd_over_q  <= bnd_over_d;
      trial_q     <= trial_d;
      succ_q      <= succ_d;
      tfull_q     <= tfull_d;
      sfull_q     <= sfull_d;
      sum_q       <= sum_d;
      verdict_q   <= verdict_d;
      frac_q      <= frac_d;
      div_start_q <= div_start_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // Serial scratch bits and the output payload.
  always_ff @(posedge clk_i) begin
    tc_q     <= tc_d;
    sc_q     <= sc_d;
    tand_q   <= tand_d;
    sand_q   <= sand_d;
    ge_q     <= ge_d;
    step_q   <= step_d;
    ac_q     <= ac_d;
    ovf_q    <= ovf_d;
    neg_q    <= neg_d;
    thr_sh_q <= thr_sh_d;
    gt_q     <= gt_d;
    lc_q     <= lc_d;
    m_data_q <= m_data_d;
  end

  // Serial divider for the success fraction.
  srt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (succ_q),
    .divisor_i  (trial_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // A trial after a decision leaves the verdict alone.
  `SRT_ASSERT_NEXT(a_verdict_held, clk_i, rst_ni, in_beat && (s_axis_tuser[0] == OP_TRIAL) && (verdict_q != VERDICT_RUN), $stable(verdict_q))
  // A fraction exists only together with the estimate verdict.
  `SRT_ASSERT_NOW(a_frac_only_est, clk_i, rst_ni, frac_q != '0, verdict_q == VERDICT_EST)
  // Between items the success count never passes the trial count.
  `SRT_ASSERT_NOW(a_succ_le_trial, clk_i, rst_ni, state_q == S_IDLE, succ_q <= trial_q)
  // While waiting on the divider it is either working or just finished.
  `SRT_ASSERT_NOW(a_div_alive, clk_i, rst_ni, (state_q == S_DIV) && !div_start_q, div_stat.busy || div_stat.done)

endmodule

>>> tb/sv/sequential_ratio_test_test.sv
// Self-checking testbench for sequential_ratio_test: directed and random trial streams,
// with random idling on both stream sides, scored beat by beat against an in-bench model.
// Depends on srt_pkg and the sequential_ratio_test RTL; reads no files.
module sequential_ratio_test_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam int     RANDOM_ITEMS   = 830;
  localparam int     STALL_LIMIT    = 5000;
  localparam int     SETTLE_CYCLES  = 8;
  localparam int     END_CYCLES     = 40;
  localparam int     REPORT_LIMIT   = 10;
  localparam int     SAMPLES_LSB    = 2;
  localparam int     SUCCESSES_LSB  = 2 + COUNT_BITS;
  localparam int     ESTIMATE_LSB   = 2 + 2 * COUNT_BITS;
  localparam longint SUM_HI         = (longint'(1) <<< (SUM_BITS - 1)) - 1;
  localparam longint SUM_LO         = -SUM_HI - 1;

  // One result beat, as predicted or as seen on the output stream.
  typedef struct {
    verdict_e                 status;
    logic [COUNT_BITS-1:0]    samples;
    logic [COUNT_BITS-1:0]    successes;
    logic [FRACTION_BITS:0]   estimate;
  } verdict_beat_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;   // [0] outcome, rest zero
  logic [IN_USER_W-1:0]   s_axis_tuser;   // [0] op
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;   // status, samples, successes, estimate
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  // Mirror of the register file.
  logic                          bound_mode;
  logic signed [STEP_BITS-1:0]   success_step_q;
  logic signed [STEP_BITS-1:0]   failure_step_q;
  logic [THR_BITS-1:0]           threshold_q;
  logic [BOUND_BITS-1:0]         bound_q;

  // Mirror of the test state.
  logic [COUNT_BITS-1:0]   trials_q;
  logic [COUNT_BITS-1:0]   successes_q;
  longint                  llr_sum_q;
  verdict_e                verdict_q;
  logic [FRACTION_BITS:0]  fraction_q;

  verdict_beat_t pending_verdicts[$];
  int            mismatches;
  int            results_seen;
  int            accepted_items;
  int            stall_cycles;
  bit            steady;

  sequential_ratio_test i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Counts, sum, verdict and estimate back to their cleared values.
  function automatic void clear_test_state();
    trials_q    = '0;
    successes_q = '0;
    llr_sum_q   = 0;
    verdict_q   = VERDICT_RUN;
    fraction_q  = '0;
  endfunction

  // Advances the mirrored test by one input beat and returns the beat it reports.
  function automatic verdict_beat_t advance_test(input logic op, input logic outcome);
    verdict_beat_t beat;
    logic [63:0]   scaled;
    if (op == OP_CLEAR) begin
      clear_test_state();
    end else if (verdict_q == VERDICT_RUN) begin
      // Both counters stick at all ones.
      if (trials_q != '1) trials_q = trials_q + 1'b1;
      if (outcome && successes_q != '1) successes_q = successes_q + 1'b1;
      if (!bound_mode) begin
        llr_sum_q += outcome ? longint'(success_step_q) : longint'(failure_step_q);
        if (llr_sum_q > SUM_HI) llr_sum_q = SUM_HI;
        else if (llr_sum_q < SUM_LO) llr_sum_q = SUM_LO;
        // A sum sitting exactly on a zero threshold decides nothing.
        if (llr_sum_q > longint'(threshold_q)) verdict_q = VERDICT_ACCEPT;
        else if (llr_sum_q < -longint'(threshold_q)) verdict_q = VERDICT_REJECT;
      end else if (trials_q >= bound_q) begin
        verdict_q  = VERDICT_EST;
        scaled     = (64'(successes_q) << FRACTION_BITS) / 64'(trials_q);
        fraction_q = scaled[FRACTION_BITS:0];
      end
    end
    beat.status    = verdict_q;
    beat.samples   = trials_q;
    beat.successes = successes_q;
    beat.estimate  = (verdict_q == VERDICT_EST) ? fraction_q : '0;
    return beat;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", msg);
  endtask

  task automatic check_field(input string field, input longint unsigned want_v,
                             input longint unsigned got_v);
    if (want_v != got_v)
      note_mismatch($sformatf("result %0d: %s expected %0d, got %0d",
                              results_seen, field, want_v, got_v));
  endtask

  // Sends one beat on the input stream, at times with a random gap in front of it (none when steady).
  // Valid is left high after the beat; whoever stops sending lowers it.
  task automatic send_beat(input logic op, input logic outcome);
    if (!steady && $urandom_range(99, 0) < 33) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(140, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_DATA_W'(outcome);
    do @(posedge clk_i); while (!s_axis_tready);
    // A trial after a verdict is ignored and does not count as stimulus.
    if (op == OP_CLEAR || verdict_q == VERDICT_RUN) accepted_items++;
    pending_verdicts.insert(pending_verdicts.size(), advance_test(op, outcome));
  endtask

  // Stops sending and waits until every expected beat has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; valid stays high until finish_writes.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MODE:          bound_mode     = value[0];
      CFG_SUCCESS_STEP:  success_step_q = value[STEP_BITS-1:0];
      CFG_FAILURE_STEP:  failure_step_q = value[STEP_BITS-1:0];
      CFG_LOG_THRESHOLD: threshold_q    = value[THR_BITS-1:0];
      CFG_SAMPLE_BOUND:  bound_q        = value[BOUND_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits for the block to go idle, then writes every register.
  task automatic configure(input logic mode, input int sstep, input int fstep,
                           input int thr, input logic [BOUND_BITS-1:0] bound);
    drain_results();
    write_reg(CFG_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_SUCCESS_STEP, CFG_DATA_W'(sstep));
    write_reg(CFG_FAILURE_STEP, CFG_DATA_W'(fstep));
    write_reg(CFG_LOG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_SAMPLE_BOUND, bound);
    finish_writes();
  endtask

  // Reset values: ratio mode with zero steps and a zero threshold never decides.
  task automatic test_zero_threshold();
    send_beat(OP_TRIAL, 1'b1);
    send_beat(OP_TRIAL, 1'b0);
    send_beat(OP_CLEAR, 1'b1);
  endtask

  // Extreme steps and thresholds, a held verdict, and steps of reversed sign.
  task automatic test_ratio_extremes();
    configure(1'b0, 8388607, -8388608, 8388607, '1);
    send_beat(OP_TRIAL, 1'b1);
    send_beat(OP_TRIAL, 1'b1);
    send_beat(OP_TRIAL, 1'b0);
    send_beat(OP_CLEAR, 1'b0);
    send_beat(OP_TRIAL, 1'b0);
    send_beat(OP_CLEAR, 1'b0);
    configure(1'b0, -8388608, 8388607, 0, 1);
    send_beat(OP_TRIAL, 1'b0);
    send_beat(OP_CLEAR, 1'b1);
  endtask

  // Bound mode: a zero bound stops on the first trial; a small bound gives a fraction.
  task automatic test_bound_mode();
    configure(1'b1, 0, 0, 0, 0);
    send_beat(OP_TRIAL, 1'b1);
    send_beat(OP_TRIAL, 1'b0);
    send_beat(OP_CLEAR, 1'b0);
    configure(1'b1, 1000, -1000, 5, 3);
    send_beat(OP_TRIAL, 1'b1);
    send_beat(OP_TRIAL, 1'b0);
    send_beat(OP_TRIAL, 1'b1);
    send_beat(OP_CLEAR, 1'b0);
  endtask

  // The mode is changed between trials of one run; counts carry over.
  task automatic test_mode_switch();
    configure(1'b1, 65536, -65536, 131072, 4);
    send_beat(OP_TRIAL, 1'b1);
    send_beat(OP_TRIAL, 1'b0);
    drain_results();
    write_reg(CFG_MODE, CFG_DATA_W'(1'b0));
    finish_writes();
    send_beat(OP_TRIAL, 1'b1);
    drain_results();
    write_reg(CFG_MODE, CFG_DATA_W'(1'b1));
    finish_writes();
    send_beat(OP_TRIAL, 1'b0);
    send_beat(OP_CLEAR, 1'b0);
  endtask

  // Picks a setting; steps are mostly scaled to the threshold so runs last a while.
  task automatic random_config();
    logic                  mode;
    int                    thr;
    int                    sstep;
    int                    fstep;
    logic [BOUND_BITS-1:0] bound;
    mode = ($urandom_range(99, 0) < 40);
    case ($urandom_range(3, 0))
      0:       thr = 0;
      1:       thr = 8388607;
      default: thr = $urandom_range(8388607, 0);
    endcase
    if ($urandom_range(3, 0) == 0) begin
      sstep = $urandom_range(16777215, 0) - 8388608;
      fstep = $urandom_range(16777215, 0) - 8388608;
    end else begin
      sstep = $urandom_range(thr / 4 + 1, 1);
      fstep = -$urandom_range(thr / 4 + 1, 1);
      if ($urandom_range(1, 0) == 1) begin
        sstep = -sstep;
        fstep = -fstep;
      end
    end
    case ($urandom_range(7, 0))
      0:       bound = '0;
      1:       bound = $urandom;
      2:       bound = '1;
      default: bound = $urandom_range(40, 1);
    endcase
    configure(mode, sstep, fstep, thr, bound);
  endtask

  // Phases of random trials; a verdict is mostly followed by a clear.
  task automatic test_random_stream();
    int   target;
    int   phase;
    int   phase_len;
    int   drain_at;
    int   success_pct;
    int   n;
    logic op;
    target = accepted_items + RANDOM_ITEMS;
    phase  = 0;
    while (accepted_items < target) begin
      random_config();
      steady      = (phase == 2);
      phase_len   = steady ? 120 : $urandom_range(120, 40);
      drain_at    = (phase % 2 == 1) ? $urandom_range(phase_len - 1, 0) : -1;
      success_pct = $urandom_range(90, 10);
      for (n = 0; n < phase_len && accepted_items < target; n++) begin
        if (n == drain_at) drain_results();
        if (verdict_q != VERDICT_RUN) op = ($urandom_range(99, 0) < 85) ? OP_CLEAR : OP_TRIAL;
        else op = ($urandom_range(99, 0) < 3) ? OP_CLEAR : OP_TRIAL;
        send_beat(op, $urandom_range(99, 0) < success_pct);
      end
      steady = 1'b0;
      phase++;
    end
  endtask

  // Output side: random back-pressure, none during the steady phase.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99, 0) >= 33);
  end

  // Scores every output beat against the oldest expectation.
  always @(posedge clk_i) begin
    verdict_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing expected: %h",
                                results_seen, m_axis_tdata));
      end else begin
        want = pending_verdicts.pop_front();
        check_field("status", want.status, m_axis_tdata[1:0]);
        check_field("samples", want.samples, m_axis_tdata[SAMPLES_LSB +: COUNT_BITS]);
        check_field("successes", want.successes,
                    m_axis_tdata[SUCCESSES_LSB +: COUNT_BITS]);
        check_field("estimate", want.estimate,
                    m_axis_tdata[ESTIMATE_LSB +: FRACTION_BITS + 1]);
      end
    end
  end

  // Ends the run when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("sequential_ratio_test verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_TRIAL;
    m_axis_tready  = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_MODE;
    cfg_data_i     = '0;
    mismatches     = 0;
    results_seen   = 0;
    accepted_items = 0;
    stall_cycles   = 0;
    steady         = 1'b0;
    bound_mode     = 1'b0;
    success_step_q = '0;
    failure_step_q = '0;
    threshold_q    = '0;
    bound_q        = BOUND_BITS'(1);
    clear_test_state();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_threshold();
    test_ratio_extremes();
    test_bound_mode();
    test_mode_switch();
    test_random_stream();

    drain_results();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sequential_ratio_test verification clean");
    end else begin
      $display("sequential_ratio_test verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/srt_pkg.sv
rtl/srt_div.sv
rtl/sequential_ratio_test.sv
tb/sv/sequential_ratio_test_test.sv
